@@ design/hashed_block_tree_address_map_assert.svh @@
// ----------------------------------------------------------------------------
// Hashed block tree address map - assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and held off
// while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef HASHED_BLOCK_TREE_ADDRESS_MAP_ASSERT_SVH
`define HASHED_BLOCK_TREE_ADDRESS_MAP_ASSERT_SVH

// same-cycle implication
`define HBTAM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("hbtam: same-cycle check failed");

// next-cycle implication
`define HBTAM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("hbtam: next-cycle check failed");

`endif

@@ design/hbtam_pkg.sv @@
// ----------------------------------------------------------------------------
// Hashed block tree address map - package
// Field widths, register indexes, level codes and inter-stage structs.
// ----------------------------------------------------------------------------
package hbtam_pkg;

    localparam int BLK_W     = 24;
    localparam int LVL_W     = 2;
    localparam int BN_W      = 26;   // internal physical block number
    localparam int HBN_W     = 25;
    localparam int OFS_W     = 37;
    localparam int HDR_W     = 32;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 104;
    localparam int M_PAD_W   = M_TDATA_W - (2 * OFS_W + HBN_W);
    localparam int S_PAD_W   = S_TDATA_W - (BLK_W + LVL_W);

    typedef enum logic [0:0] {
        REG_READ_ONLY = 1'b0,
        REG_HDR_BYTES = 1'b1
    } t_reg_idx;

    localparam logic [LVL_W-1:0] LVL_LEAF = 2'd0;
    localparam logic [LVL_W-1:0] LVL_MID  = 2'd1;

    typedef struct packed {
        logic [BLK_W-1:0] blk;
        logic [LVL_W-1:0] lvl;
    } t_req;

    typedef struct packed {
        logic [BLK_W-1:0] blk;
        logic [LVL_W-1:0] lvl;
        logic [BLK_W-1:0] q0;   // blk / H
        logic [BLK_W-1:0] q1;   // blk / H^2
        logic [BLK_W-1:0] q2;   // blk / H^3
    } t_quot;

endpackage

@@ design/hashed_block_tree_address_map.sv @@
// ----------------------------------------------------------------------------
// Hashed block tree address map - top level
// Maps a logical block and tree level to data and hash table byte offsets.
// ----------------------------------------------------------------------------
// One lookup is accepted every clock cycle while s_axis_tready is high; its
// result passes the input register, the reciprocal-divide quotient register,
// the block number register and the offset output register. Each stage holds
// its item only while the stage after it is full and stalled, so bubbles are
// squeezed out and input beats keep flowing while a result waits until all
// four stages are full. Registers (APB, byte address 4*i): 0 read_only_layout
// (bit 0), 1 header length in bytes. Write them only while no lookup is in
// flight.
module hashed_block_tree_address_map #(
    parameter int HASHES_PER_BLOCK = 170,
    parameter int BLOCK_BYTES      = 4096
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [23:0] block_number, [25:24] hash_level, [31:26] zero
    input  logic [hbtam_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [36:0] data_offset, [61:37] hash_block_number,
    // [98:62] hash_block_offset, [103:99] zero
    output logic [hbtam_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [hbtam_pkg::APB_AW-1:0]      paddr,
    input  logic [hbtam_pkg::APB_DW-1:0]      pwdata,
    output logic [hbtam_pkg::APB_DW-1:0]      prdata,
    output logic                              pready
);
    import hbtam_pkg::*;

    `include "hashed_block_tree_address_map_assert.svh"

    localparam logic [OFS_W-1:0] BB_C = OFS_W'(BLOCK_BYTES);

    logic                 r_read_only;
    logic [HDR_W-1:0]     r_hdr_bytes;
    t_reg_idx             reg_idx;
    logic                 cfg_wr;

    logic                 r_v1;
    logic                 r_v2;
    logic                 r_v3;
    logic                 r_v4;
    logic                 rdy1;
    logic                 rdy2;
    logic                 rdy3;
    logic                 rdy4;
    t_req                 r_req;
    t_quot                quot;
    logic [BN_W-1:0]      map_phys;
    logic [BN_W-1:0]      map_hnum;
    logic [OFS_W-1:0]     data_ofs;
    logic [OFS_W-1:0]     hash_ofs;
    logic [M_TDATA_W-1:0] n_out;
    logic [M_TDATA_W-1:0] r_out;

    // configuration
    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_read_only <= 1'b0;
            r_hdr_bytes <= '0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_READ_ONLY: r_read_only <= pwdata[0];
                REG_HDR_BYTES: r_hdr_bytes <= pwdata;
                default:       r_hdr_bytes <= r_hdr_bytes;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_READ_ONLY: prdata = APB_DW'(r_read_only);
            REG_HDR_BYTES: prdata = r_hdr_bytes;
            default:       prdata = '0;
        endcase
    end

    // stage flow control
    assign rdy4          = !r_v4 || m_axis_tready;
    assign rdy3          = !r_v3 || rdy4;
    assign rdy2          = !r_v2 || rdy3;
    assign rdy1          = !r_v1 || rdy2;
    assign s_axis_tready = rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= s_axis_tvalid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
            if (rdy4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && s_axis_tvalid) begin
            r_req.blk <= s_axis_tdata[BLK_W-1:0];
            r_req.lvl <= s_axis_tdata[BLK_W +: LVL_W];
        end
    end

    hbtam_quot #(
        .HASHES_PER_BLOCK(HASHES_PER_BLOCK)
    ) u_quot (
        .i_clk  (i_clk),
        .i_en   (rdy2),
        .i_req  (r_req),
        .o_quot (quot)
    );

    hbtam_map #(
        .HASHES_PER_BLOCK(HASHES_PER_BLOCK)
    ) u_map (
        .i_clk       (i_clk),
        .i_en        (rdy3),
        .i_read_only (r_read_only),
        .i_quot      (quot),
        .o_phys      (map_phys),
        .o_hnum      (map_hnum)
    );

    // byte offsets, modulo the field width
    assign data_ofs = OFS_W'(r_hdr_bytes) + OFS_W'(map_phys) * BB_C;
    assign hash_ofs = OFS_W'(r_hdr_bytes) + OFS_W'(map_hnum) * BB_C;
    assign n_out    = {{M_PAD_W{1'b0}}, hash_ofs, map_hnum[HBN_W-1:0], data_ofs};

    always_ff @(posedge i_clk) begin
        if (rdy4) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_v4;
    assign m_axis_tdata  = r_out;

    `HBTAM_ASSERT_IMPL(a_ready_when_empty, i_clk, i_rst_n, !r_v1, s_axis_tready)
    `HBTAM_ASSERT_NEXT(a_quot_hold, i_clk, i_rst_n, r_v2 && r_v3 && r_v4 && !m_axis_tready, r_v2)
    `HBTAM_ASSERT_IMPL(a_table_not_data, i_clk, i_rst_n, r_v3, map_phys != map_hnum)

endmodule

@@ design/hbtam_quot.sv @@
// ----------------------------------------------------------------------------
// Hashed block tree address map - quotient stage
// Divides the block number by H, H^2 and H^3 through exact reciprocal
// multiplication and registers the quotients.
// ----------------------------------------------------------------------------
module hbtam_quot #(
    parameter int HASHES_PER_BLOCK = 170
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  hbtam_pkg::t_req  i_req,
    output hbtam_pkg::t_quot o_quot
);
    import hbtam_pkg::*;

    localparam longint unsigned D0 = longint'(HASHES_PER_BLOCK);
    localparam longint unsigned D1 = D0 * D0;
    localparam longint unsigned D2 = D1 * D0;
    localparam int S0 = BLK_W + $clog2(D0);
    localparam int S1 = BLK_W + $clog2(D1);
    localparam int S2 = BLK_W + $clog2(D2);
    // ceil(2^S / D): exact quotient for every BLK_W-bit dividend
    localparam longint unsigned M0 = ((64'd1 << S0) + D0 - 64'd1) / D0;
    localparam longint unsigned M1 = ((64'd1 << S1) + D1 - 64'd1) / D1;
    localparam longint unsigned M2 = ((64'd1 << S2) + D2 - 64'd1) / D2;
    localparam int MW = BLK_W + 2;
    localparam int PW = BLK_W + MW;
    localparam logic [PW-1:0] M0_C = PW'(M0);
    localparam logic [PW-1:0] M1_C = PW'(M1);
    localparam logic [PW-1:0] M2_C = PW'(M2);

    logic [PW-1:0] p0;
    logic [PW-1:0] p1;
    logic [PW-1:0] p2;
    t_quot         n_quot;
    t_quot         r_quot;

    assign p0 = PW'(i_req.blk) * M0_C;
    assign p1 = PW'(i_req.blk) * M1_C;
    assign p2 = PW'(i_req.blk) * M2_C;

    always_comb begin
        n_quot.blk = i_req.blk;
        n_quot.lvl = i_req.lvl;
        n_quot.q0  = BLK_W'(p0 >> S0);
        n_quot.q1  = BLK_W'(p1 >> S1);
        n_quot.q2  = BLK_W'(p2 >> S2);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quot <= n_quot;
        end
    end

    assign o_quot = r_quot;

endmodule

@@ design/hbtam_map.sv @@
// ----------------------------------------------------------------------------
// Hashed block tree address map - block number stage
// Builds the physical data block and the covering hash table block from the
// quotients and registers both.
// ----------------------------------------------------------------------------
module hbtam_map #(
    parameter int HASHES_PER_BLOCK = 170
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic                        i_read_only,
    input  hbtam_pkg::t_quot            i_quot,
    output logic [hbtam_pkg::BN_W-1:0]  o_phys,
    output logic [hbtam_pkg::BN_W-1:0]  o_hnum
);
    import hbtam_pkg::*;

    localparam logic [BN_W-1:0] H_C  = BN_W'(HASHES_PER_BLOCK);
    localparam logic [BN_W-1:0] H1_C = BN_W'(HASHES_PER_BLOCK + 1);
    localparam logic [BN_W-1:0] H2_C = BN_W'(HASHES_PER_BLOCK * HASHES_PER_BLOCK);

    logic            sh;      // tables per group = 1 << sh
    logic [BN_W-1:0] copies;
    logic [BN_W-1:0] blk;
    logic [BN_W-1:0] q0;
    logic [BN_W-1:0] q1;
    logic [BN_W-1:0] q2;
    logic [BN_W-1:0] step0;
    logic [BN_W-1:0] step1;
    logic [BN_W-1:0] n_phys;
    logic [BN_W-1:0] n_hnum;
    logic [BN_W-1:0] r_phys;
    logic [BN_W-1:0] r_hnum;

    assign sh     = !i_read_only;
    assign copies = BN_W'(1) << sh;
    assign blk    = BN_W'(i_quot.blk);
    assign q0     = BN_W'(i_quot.q0);
    assign q1     = BN_W'(i_quot.q1);
    assign q2     = BN_W'(i_quot.q2);
    assign step0  = H_C + copies;
    assign step1  = H2_C + (H1_C << sh);

    always_comb begin
        n_phys = blk + ((q0 + BN_W'(1)) << sh);
        if (q0 != '0) begin
            n_phys = n_phys + ((q1 + BN_W'(1)) << sh);
        end
        if (q1 != '0) begin
            n_phys = n_phys + ((q2 + BN_W'(1)) << sh);
        end
    end

    always_comb begin
        priority if (i_quot.lvl == LVL_LEAF) begin
            if (q0 == '0) begin
                n_hnum = '0;
            end else begin
                n_hnum = q0 * H_C + (q0 << sh) + ((q1 + BN_W'(1)) << sh)
                       + ((q1 != '0) ? copies : '0);
            end
        end else if (i_quot.lvl == LVL_MID) begin
            if (q1 == '0) begin
                n_hnum = step0;
            end else begin
                n_hnum = q1 * H2_C + ((q1 * H1_C) << sh) + copies;
            end
        end else begin
            // top level; the unused code answers as the top level too
            n_hnum = step1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_phys <= n_phys;
            r_hnum <= n_hnum;
        end
    end

    assign o_phys = r_phys;
    assign o_hnum = r_hnum;

endmodule
